>>> design/wvsd_pkg.sv
`timescale 1ns / 1ps

package wvsd_pkg;

    // Field widths
    localparam int COMPONENT_WIDTH = 16;
    localparam int DIR_W           = 15;

    // CORDIC sizing
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 32;
    localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int GUARD_BITS    = 16;
    // Input scaled by 2^GUARD_BITS, one bit for negation, two for CORDIC growth
    localparam int XY_W          = COMPONENT_WIDTH + GUARD_BITS + 3;
    localparam int UX_W          = XY_W - 1;
    localparam int Z_W           = 27;
    localparam int ATAN_W        = 22;

    // Gain correction and output scaling
    localparam int                 GAIN_W      = 30;
    localparam logic [GAIN_W-1:0]  GAIN_Q30    = GAIN_W'(652032874);
    localparam int                 SPEED_SHIFT = GAIN_W + GUARD_BITS;
    localparam int                 SPLIT       = UX_W / 2;
    localparam int                 PROD_W      = UX_W + GAIN_W + 1;

    // Angle constants, units of 2^-16 degree
    localparam logic signed [Z_W-1:0] HALF_TURN_Q16 = Z_W'(180 * 65536);
    localparam int                    DIR_ROUND     = 512;
    localparam int                    DIR_SHIFT     = 10;
    localparam logic [DIR_W-1:0]      DIR_MAX       = DIR_W'(23040);
    localparam logic [DIR_W-1:0]      DIR_ZERO_VEC  = DIR_W'(11520);

    // round(atan(2^-i) * 180/pi * 65536)
    localparam logic [ATAN_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
        ATAN_W'(2949120), ATAN_W'(1740967), ATAN_W'(919879), ATAN_W'(466945),
        ATAN_W'(234379),  ATAN_W'(117304),  ATAN_W'(58666),  ATAN_W'(29335),
        ATAN_W'(14668),   ATAN_W'(7334),    ATAN_W'(3667),   ATAN_W'(1833),
        ATAN_W'(917),     ATAN_W'(458),     ATAN_W'(229),    ATAN_W'(115),
        ATAN_W'(57),      ATAN_W'(29),      ATAN_W'(14),     ATAN_W'(7),
        ATAN_W'(4),       ATAN_W'(2),       ATAN_W'(1),      ATAN_W'(0),
        ATAN_W'(0),       ATAN_W'(0),       ATAN_W'(0),      ATAN_W'(0),
        ATAN_W'(0),       ATAN_W'(0),       ATAN_W'(0),      ATAN_W'(0)
    };

    // Vector state carried down the pipeline
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero_vec;
    } wvsd_vec_t;

endpackage

>>> design/wvsd_prep.sv
`timescale 1ns / 1ps

module wvsd_prep
    import wvsd_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_u_component,
    input  logic signed [COMPONENT_WIDTH-1:0] s_v_component,
    output logic                              out_valid,
    input  logic                              out_ready,
    output wvsd_vec_t                         out_vec
);

    logic      valid_reg;
    wvsd_vec_t vec_reg;
    wvsd_vec_t vec_next;

    // Scale up; fold the left half-plane onto the right one
    always_comb begin
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = XY_W'(s_v_component) <<< GUARD_BITS;
        ys = XY_W'(s_u_component) <<< GUARD_BITS;
        vec_next.zero_vec = (s_u_component == '0) && (s_v_component == '0);
        if (s_v_component < 0) begin
            vec_next.x = -xs;
            vec_next.y = -ys;
            vec_next.z = (s_u_component >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
        end else begin
            vec_next.x = xs;
            vec_next.y = ys;
            vec_next.z = '0;
        end
    end

    assign s_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

>>> design/wvsd_cordic.sv
`timescale 1ns / 1ps

module wvsd_cordic
    import wvsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  wvsd_vec_t in_vec,
    output logic      out_valid,
    input  logic      out_ready,
    output wvsd_vec_t out_vec
);

    logic      valid_reg [NUM_STAGES];
    wvsd_vec_t vec_reg   [NUM_STAGES];
    logic      rdy       [NUM_STAGES+1];

    assign rdy[NUM_STAGES] = out_ready;

    // One vectoring iteration per register stage
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_Q16[i]);

        wvsd_vec_t src;
        logic      src_valid;
        wvsd_vec_t vec_next;

        if (i == 0) begin : g_first
            assign src       = in_vec;
            assign src_valid = in_valid;
        end else begin : g_rest
            assign src       = vec_reg[i-1];
            assign src_valid = valid_reg[i-1];
        end

        // Drive y toward zero, accumulate the rotation angle
        always_comb begin
            logic signed [XY_W-1:0] xs;
            logic signed [XY_W-1:0] ys;
            xs = src.x >>> i;
            ys = src.y >>> i;
            vec_next.zero_vec = src.zero_vec;
            if (!src.y[XY_W-1]) begin
                vec_next.x = src.x + ys;
                vec_next.y = src.y - xs;
                vec_next.z = src.z + ANG;
            end else begin
                vec_next.x = src.x - ys;
                vec_next.y = src.y + xs;
                vec_next.z = src.z - ANG;
            end
        end

        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && src_valid) begin
                vec_reg[i] <= vec_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_vec   = vec_reg[NUM_STAGES-1];

endmodule

>>> design/wvsd_scale.sv
`timescale 1ns / 1ps

module wvsd_scale
    import wvsd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  wvsd_vec_t                  in_vec,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COMPONENT_WIDTH-1:0] m_speed,
    output logic [DIR_W-1:0]           m_heading
);

    localparam int HI_W   = UX_W - SPLIT;
    localparam int SPD_W  = PROD_W - SPEED_SHIFT;
    localparam int ZS_W   = Z_W + 1;
    localparam int DS_W   = ZS_W - DIR_SHIFT;

    typedef struct packed {
        logic [SPLIT+GAIN_W-1:0] p_lo;
        logic [HI_W+GAIN_W-1:0]  p_hi;
        logic signed [Z_W-1:0]   z;
        logic                    zero_vec;
    } wvsd_prod_t;

    // Stage A: gain multiply as two partial products
    logic       a_valid_reg;
    wvsd_prod_t a_reg;
    wvsd_prod_t a_next;
    logic       a_ready;

    // Stage B: combine, round, saturate; direction offset and clamp
    logic                       m_valid_reg;
    logic [COMPONENT_WIDTH-1:0] speed_reg;
    logic [COMPONENT_WIDTH-1:0] speed_next;
    logic [DIR_W-1:0]           dir_reg;
    logic [DIR_W-1:0]           dir_next;
    logic                       b_ready;

    always_comb begin
        logic [UX_W-1:0] ux;
        ux = (in_vec.x > 0) ? in_vec.x[UX_W-1:0] : '0;
        a_next.p_lo     = ux[SPLIT-1:0] * GAIN_Q30;
        a_next.p_hi     = ux[UX_W-1:SPLIT] * GAIN_Q30;
        a_next.z        = in_vec.z;
        a_next.zero_vec = in_vec.zero_vec;
    end

    assign b_ready  = !m_valid_reg || m_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_reg <= a_next;
        end
    end

    always_comb begin
        logic [PROD_W-1:0]      prod;
        logic [SPD_W-1:0]       spd;
        logic signed [ZS_W-1:0] zs;
        logic signed [DS_W-1:0] ds;
        prod = (PROD_W'(a_reg.p_hi) << SPLIT) + PROD_W'(a_reg.p_lo)
             + (PROD_W'(1) << (SPEED_SHIFT - 1));
        spd  = prod[PROD_W-1:SPEED_SHIFT];
        zs   = ZS_W'(a_reg.z) + ZS_W'(HALF_TURN_Q16) + ZS_W'(DIR_ROUND);
        ds   = DS_W'(zs >>> DIR_SHIFT);
        if (a_reg.zero_vec) begin
            speed_next = '0;
            dir_next   = DIR_ZERO_VEC;
        end else begin
            if (|spd[SPD_W-1:COMPONENT_WIDTH]) begin
                speed_next = '1;
            end else begin
                speed_next = spd[COMPONENT_WIDTH-1:0];
            end
            if (ds < 0) begin
                dir_next = '0;
            end else if (ds > DS_W'(DIR_MAX)) begin
                dir_next = DIR_MAX;
            end else begin
                dir_next = ds[DIR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_ready) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            speed_reg <= speed_next;
            dir_reg   <= dir_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_speed   = speed_reg;
    assign m_heading = dir_reg;

endmodule

>>> design/wind_vector_speed_direction.sv
`timescale 1ns / 1ps

// Wind speed and direction from u (eastward) and v (northward) components in
// signed Q8.8. Speed is the gain-corrected CORDIC magnitude in unsigned Q8.8,
// saturated to 16 bits; direction is atan2(u, v) + 180 degrees in 1/64 degree,
// clamped to 0..23040, and a zero vector gives speed 0, direction 180 degrees.
// Fully pipelined: one point per cycle while m_ready is held high, with one fold
// stage, one register per CORDIC iteration, one
// stage for the gain multiply, one output register. Each stage holds while the
// next is full and stalled, so back-pressure on m_ready stops nothing upstream
// until the pipeline fills behind it.
module wind_vector_speed_direction
    import wvsd_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_u_component,
    input  logic signed [COMPONENT_WIDTH-1:0] s_v_component,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COMPONENT_WIDTH-1:0]        m_speed,
    output logic [DIR_W-1:0]                  m_heading
);

    logic      prep_valid;
    logic      prep_ready;
    wvsd_vec_t prep_vec;
    logic      cordic_valid;
    logic      cordic_ready;
    wvsd_vec_t cordic_vec;

    wvsd_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_u_component (s_u_component),
        .s_v_component (s_v_component),
        .out_valid     (prep_valid),
        .out_ready     (prep_ready),
        .out_vec       (prep_vec)
    );

    wvsd_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_vec    (prep_vec),
        .out_valid (cordic_valid),
        .out_ready (cordic_ready),
        .out_vec   (cordic_vec)
    );

    wvsd_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cordic_valid),
        .in_ready  (cordic_ready),
        .in_vec    (cordic_vec),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_speed   (m_speed),
        .m_heading (m_heading)
    );

endmodule
